FILE: sv/keystroke_line_buffer_core_defines.svh
// Assertion macros shared by the keystroke line buffer RTL.
`ifndef KEYSTROKE_LINE_BUFFER_CORE_DEFINES_SVH
`define KEYSTROKE_LINE_BUFFER_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define KLB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define KLB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/klb_pkg.sv
// Types and constants of the keystroke line buffer.
`timescale 1ns / 1ps

package klb_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 6;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_LINE = 2'd1,
    OP_CHAR = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ECHO      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LINE_CHAR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_END  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SINGLE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVAL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTAVAIL = 2'd2;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

  // Which result the datapath loads into its output register
  typedef enum logic [2:0] {
    EMIT_ECHO,
    EMIT_LINE_CHAR,
    EMIT_LINE_END,
    EMIT_SINGLE,
    EMIT_ERR_INVAL,
    EMIT_ERR_NOTAVAIL
  } emit_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SINGLE,
    S_LINE_ADDR,
    S_LINE_EMIT,
    S_LINE_END,
    S_SCAN_ADDR,
    S_SCAN_CHK
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic  capture;
    logic  add_key;
    logic  line_start;
    logic  line_adv;
    logic  single_adv;
    logic  line_finish;
    logic  scan_adv;
    logic  scan_clear;
    logic  rd_sel_nl;
    logic  out_load;
    emit_t emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic len_bad;
    logic pending;
    logic empty;
    logic line_stop;
    logic scan_hit_w;
    logic scan_hit_nl;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/klb_in_if.sv
// Input channel: one request item per handshake.
`timescale 1ns / 1ps

interface klb_in_if;
  logic                        valid;
  logic                        ready;
  logic [klb_pkg::OP_W-1:0]    operation;
  logic [klb_pkg::CHAR_W-1:0]  key_char;
  logic [klb_pkg::LEN_W-1:0]   max_len;

  modport source (output valid, operation, key_char, max_len, input ready);
  modport sink   (input valid, operation, key_char, max_len, output ready);
endinterface

FILE: sv/klb_out_if.sv
// Output channel: one result item per handshake.
`timescale 1ns / 1ps

interface klb_out_if;
  logic                          valid;
  logic                          ready;
  logic [klb_pkg::KIND_W-1:0]    kind;
  logic [klb_pkg::CHAR_W-1:0]    char_out;
  logic [klb_pkg::STATUS_W-1:0]  status;
  logic [klb_pkg::COUNT_W-1:0]   byte_count;
  logic                          last;

  modport source (output valid, kind, char_out, status, byte_count, last, input ready);
  modport sink   (input valid, kind, char_out, status, byte_count, last, output ready);
endinterface

FILE: sv/keystroke_line_buffer_core.sv
// Keystroke line buffer: ring of keys with line reads, char pops and newline rescan.
// Add or error: accepted in idle, result loaded in decode; char pop: decode, then single.
// Line read: line address and line emit per char, line end, then scan address and scan
// check per slot rescanned; a new item is taken only back in idle, when the last is done.
// A result waiting in the output register stalls the controller until it is taken.
// Reset clears indices, newline flag and control and holds input ready low; keys undefined.
`timescale 1ns / 1ps

module keystroke_line_buffer_core #(
  parameter int BUFFER_DEPTH = 32
) (
  input logic       clk,
  input logic       rst,
  klb_in_if.sink    keys,
  klb_out_if.source results
);

  klb_pkg::cmd_t cmd;
  klb_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  klb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (keys.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  klb_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .operation  (keys.operation),
    .key_char   (keys.key_char),
    .max_len    (keys.max_len),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (results.ready),
    .kind       (results.kind),
    .char_out   (results.char_out),
    .status     (results.status),
    .byte_count (results.byte_count),
    .last       (results.last)
  );

  assign keys.ready    = in_ready;
  assign results.valid = out_valid;

endmodule

FILE: sv/klb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module klb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/klb_ctrl.sv
// Controller state machine of the keystroke line buffer.
`timescale 1ns / 1ps

module klb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  klb_pkg::sts_t sts,
  output klb_pkg::cmd_t cmd
);

  klb_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= klb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      klb_pkg::S_IDLE: begin
        if (in_valid) state_next = klb_pkg::S_DECODE;
      end
      klb_pkg::S_DECODE: begin
        case (sts.op)
          klb_pkg::OP_ADD: begin
            if (sts.full || sts.out_free) state_next = klb_pkg::S_IDLE;
          end
          klb_pkg::OP_LINE: begin
            if (sts.len_bad || !sts.pending) begin
              if (sts.out_free) state_next = klb_pkg::S_IDLE;
            end else begin
              state_next = klb_pkg::S_LINE_ADDR;
            end
          end
          klb_pkg::OP_CHAR: begin
            if (!sts.empty) begin
              state_next = klb_pkg::S_SINGLE;
            end else if (sts.out_free) begin
              state_next = klb_pkg::S_IDLE;
            end
          end
          default: state_next = klb_pkg::S_IDLE;
        endcase
      end
      klb_pkg::S_SINGLE: begin
        if (sts.out_free) state_next = klb_pkg::S_IDLE;
      end
      klb_pkg::S_LINE_ADDR: begin
        state_next = sts.line_stop ? klb_pkg::S_LINE_END : klb_pkg::S_LINE_EMIT;
      end
      klb_pkg::S_LINE_EMIT: begin
        if (sts.out_free) state_next = klb_pkg::S_LINE_ADDR;
      end
      klb_pkg::S_LINE_END: begin
        if (sts.out_free) state_next = klb_pkg::S_SCAN_ADDR;
      end
      klb_pkg::S_SCAN_ADDR: begin
        state_next = sts.scan_hit_w ? klb_pkg::S_IDLE : klb_pkg::S_SCAN_CHK;
      end
      klb_pkg::S_SCAN_CHK: begin
        state_next = sts.scan_hit_nl ? klb_pkg::S_IDLE : klb_pkg::S_SCAN_ADDR;
      end
      default: state_next = klb_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.emit = klb_pkg::EMIT_ECHO;
    in_ready = 1'b0;
    case (state)
      klb_pkg::S_IDLE: begin
        // Hold off input items while in reset
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      klb_pkg::S_DECODE: begin
        case (sts.op)
          klb_pkg::OP_ADD: begin
            if (!sts.full && sts.out_free) begin
              cmd.add_key  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.emit     = klb_pkg::EMIT_ECHO;
            end
          end
          klb_pkg::OP_LINE: begin
            if (sts.len_bad) begin
              cmd.out_load = sts.out_free;
              cmd.emit     = klb_pkg::EMIT_ERR_INVAL;
            end else if (!sts.pending) begin
              cmd.out_load = sts.out_free;
              cmd.emit     = klb_pkg::EMIT_ERR_NOTAVAIL;
            end else begin
              cmd.line_start = 1'b1;
            end
          end
          klb_pkg::OP_CHAR: begin
            if (sts.empty) begin
              cmd.out_load = sts.out_free;
              cmd.emit     = klb_pkg::EMIT_ERR_NOTAVAIL;
            end
          end
          default: ;
        endcase
      end
      klb_pkg::S_SINGLE: begin
        cmd.out_load   = sts.out_free;
        cmd.single_adv = sts.out_free;
        cmd.emit       = klb_pkg::EMIT_SINGLE;
      end
      klb_pkg::S_LINE_ADDR: ;
      klb_pkg::S_LINE_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.line_adv = sts.out_free;
        cmd.emit     = klb_pkg::EMIT_LINE_CHAR;
      end
      klb_pkg::S_LINE_END: begin
        cmd.out_load    = sts.out_free;
        cmd.line_finish = sts.out_free;
        cmd.emit        = klb_pkg::EMIT_LINE_END;
      end
      klb_pkg::S_SCAN_ADDR: begin
        cmd.rd_sel_nl  = 1'b1;
        cmd.scan_clear = sts.scan_hit_w;
      end
      klb_pkg::S_SCAN_CHK: begin
        cmd.rd_sel_nl = 1'b1;
        cmd.scan_adv  = !sts.scan_hit_nl;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/klb_dp.sv
// Datapath of the keystroke line buffer: ring indices, key store and result register.
`timescale 1ns / 1ps
`include "keystroke_line_buffer_core_defines.svh"

module klb_dp #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [klb_pkg::OP_W-1:0]        operation,
  input  logic [klb_pkg::CHAR_W-1:0]      key_char,
  input  logic [klb_pkg::LEN_W-1:0]       max_len,
  input  klb_pkg::cmd_t                   cmd,
  output klb_pkg::sts_t                   sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [klb_pkg::KIND_W-1:0]      kind,
  output logic [klb_pkg::CHAR_W-1:0]      char_out,
  output logic [klb_pkg::STATUS_W-1:0]    status,
  output logic [klb_pkg::COUNT_W-1:0]     byte_count,
  output logic                            last
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_DEPTH - 1);

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] prv(input logic [IW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  klb_pkg::op_t                   op_q;
  logic [klb_pkg::CHAR_W-1:0]     key_q;
  logic [klb_pkg::LEN_W-1:0]      len_q;
  logic [IW-1:0]                  read_index;
  logic [IW-1:0]                  write_index;
  logic [IW-1:0]                  newline_index;
  logic                           newline_pending;
  logic [klb_pkg::COUNT_W-1:0]    line_count;
  logic [IW-1:0]                  rd_addr;
  logic [klb_pkg::CHAR_W-1:0]     rd_data;
  logic                           out_free;

  logic [klb_pkg::KIND_W-1:0]     kind_next;
  logic [klb_pkg::CHAR_W-1:0]     char_next;
  logic [klb_pkg::STATUS_W-1:0]   status_next;
  logic [klb_pkg::COUNT_W-1:0]    count_next;
  logic                           last_next;

  // Key store
  assign rd_addr = cmd.rd_sel_nl ? newline_index : read_index;

  klb_ram #(
    .WIDTH (klb_pkg::CHAR_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (cmd.add_key),
    .wr_addr (write_index),
    .wr_data (key_q),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= klb_pkg::op_t'(operation);
      key_q <= key_char;
      len_q <= max_len;
    end
  end

  // Ring indices and newline tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index      <= '0;
      write_index     <= '0;
      newline_index   <= '0;
      newline_pending <= 1'b0;
    end else begin
      if (cmd.add_key) begin
        if (key_q == klb_pkg::CH_NEWLINE && !newline_pending) begin
          newline_index   <= write_index;
          newline_pending <= 1'b1;
        end
        if (key_q == klb_pkg::CH_BACKSPACE) begin
          if (write_index != read_index) write_index <= prv(write_index);
        end else begin
          write_index <= nxt(write_index);
        end
      end else if (cmd.line_adv || cmd.single_adv) begin
        read_index <= nxt(read_index);
      end else if (cmd.line_finish) begin
        // Drop the rest of the line through its newline, start the rescan
        read_index    <= nxt(newline_index);
        newline_index <= nxt(newline_index);
      end else if (cmd.scan_adv) begin
        newline_index <= nxt(newline_index);
      end else if (cmd.scan_clear) begin
        newline_pending <= 1'b0;
      end
    end
  end

  // Count characters of a line read
  always_ff @(posedge clk) begin
    if (cmd.line_start) begin
      line_count <= '0;
    end else if (cmd.line_adv) begin
      line_count <= line_count + 1'b1;
    end
  end

  // Status to the controller
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.op          = op_q;
    sts.full        = (nxt(write_index) == read_index);
    sts.len_bad     = (int'(len_q) >= BUFFER_DEPTH);
    sts.pending     = newline_pending;
    sts.empty       = (read_index == write_index);
    sts.line_stop   = (line_count == len_q) || (read_index == newline_index);
    sts.scan_hit_w  = (newline_index == write_index);
    sts.scan_hit_nl = (rd_data == klb_pkg::CH_NEWLINE);
    sts.out_free    = out_free;
  end

  // Build the next result
  always_comb begin
    kind_next   = klb_pkg::KIND_ECHO;
    char_next   = '0;
    status_next = klb_pkg::ST_OK;
    count_next  = '0;
    last_next   = 1'b1;
    case (cmd.emit)
      klb_pkg::EMIT_ECHO: begin
        char_next = key_q;
      end
      klb_pkg::EMIT_LINE_CHAR: begin
        kind_next = klb_pkg::KIND_LINE_CHAR;
        char_next = rd_data;
        last_next = 1'b0;
      end
      klb_pkg::EMIT_LINE_END: begin
        kind_next  = klb_pkg::KIND_LINE_END;
        // Stopping short of the limit means the newline was reached
        char_next  = (line_count != len_q) ? klb_pkg::CH_NEWLINE : '0;
        count_next = line_count;
      end
      klb_pkg::EMIT_SINGLE: begin
        kind_next = klb_pkg::KIND_SINGLE;
        char_next = rd_data;
      end
      klb_pkg::EMIT_ERR_INVAL: begin
        kind_next   = klb_pkg::KIND_ERROR;
        status_next = klb_pkg::ST_INVAL;
      end
      klb_pkg::EMIT_ERR_NOTAVAIL: begin
        kind_next   = klb_pkg::KIND_ERROR;
        status_next = klb_pkg::ST_NOTAVAIL;
      end
      default: ;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind       <= kind_next;
      char_out   <= char_next;
      status     <= status_next;
      byte_count <= count_next;
      last       <= last_next;
    end
  end

  // A result must never overwrite one that is still waiting
  `KLB_ASSERT(a_load_free, clk, rst, cmd.out_load |-> out_free, "result overwritten")
  // A key is stored only when the ring has room
  `KLB_ASSERT(a_add_room, clk, rst, cmd.add_key |-> !sts.full, "key stored into full ring")
  // A line character is read only before the stop condition
  `KLB_ASSERT(a_line_adv, clk, rst, cmd.line_adv |-> !sts.line_stop, "read past line stop")
  // Finishing a line leaves read and newline indices together
  `KLB_ASSERT(a_finish_idx, clk, rst, cmd.line_finish |=> read_index == newline_index,
              "indices apart after line read")

endmodule
